>>> hdl/rgbnpi_pkg.sv
package rgbnpi_pkg;

  localparam int ChanW  = 8;
  localparam int Col15W = 15;
  localparam int EntryW = 3 * ChanW;
  localparam int SqW    = 2 * ChanW;
  localparam int DistW  = SqW + 2;
  localparam int WordW  = 32;

  // item opcodes
  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [ChanW-1:0] AlphaFull = 8'hFF;

  typedef struct packed {
    logic              op;
    logic [ChanW-1:0]  entry_index;
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
    logic [Col15W-1:0] color15;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0] best_index;
    logic [WordW-1:0] packed_entry;
  } out_item_t;

  typedef struct packed {
    logic             en;
    logic [ChanW-1:0] addr;
    logic [EntryW-1:0] data;
  } pal_wr_t;

  // 5-bit channel to 8 bits at the centre of its bucket
  function automatic logic [ChanW-1:0] expand5(input logic [4:0] v);
    return {v, 3'b100};
  endfunction

  function automatic logic [SqW-1:0] chan_sq(input logic [ChanW-1:0] a,
                                             input logic [ChanW-1:0] b);
    logic [ChanW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SqW'(d) * SqW'(d);
  endfunction

endpackage

>>> hdl/rgbnpi_palette.sv
module rgbnpi_palette #(
  parameter int Entries = 256,
  parameter int AddrW   = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rgbnpi_pkg::pal_wr_t          wr_i,
  input  logic [AddrW-1:0]             rd_addr_i,
  output logic [rgbnpi_pkg::EntryW-1:0] rd_data_o
);
  import rgbnpi_pkg::*;

  logic [EntryW-1:0] mem_q [Entries];
  logic [Entries-1:0] vld_q;
  logic [EntryW-1:0] rd_raw_q;
  logic              rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[AddrW-1:0]] <= wr_i.data;
    end
    rd_raw_q <= mem_q[rd_addr_i];
  end

  // entries never written since reset read as black
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr[AddrW-1:0]] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_raw_q : '0;

endmodule

>>> hdl/rgb555_nearest_palette_index.sv
// write item: accepted in idle, held in the result registers until the output register is free
// query item: one palette read per cycle over all PALETTE_ENTRIES entries, then a
//   three-deep read/square/compare pipe
// one item in flight at a time; the next is taken once the result sits in the output register
// reset clears control state and the per-entry valid flags, so every entry reads as black
module rgb555_nearest_palette_index #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rgbnpi_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rgbnpi_pkg::out_item_t out_item_o
);
  import rgbnpi_pkg::*;

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [AW-1:0]    LastAddr = AW'(PALETTE_ENTRIES - 1);
  localparam logic [ChanW-1:0] LastIdx  = ChanW'(PALETTE_ENTRIES - 1);

  typedef enum logic [1:0] {StIdle, StScan, StDrain, StFinish} state_e;

  state_e state_q;

  logic [AW-1:0]     scan_addr_q;
  logic              s1_vld_q, s2_vld_q;
  logic [AW-1:0]     s1_idx_q, s2_idx_q;
  logic [EntryW-1:0] rd_data;
  logic [EntryW-1:0] s2_data_q;
  logic [SqW-1:0]    sq_r_q, sq_g_q, sq_b_q;
  logic [ChanW-1:0]  q_r_q, q_g_q, q_b_q;
  logic [DistW-1:0]  best_d_q, dist_sum;
  logic [ChanW-1:0]  res_index_q;
  logic [EntryW-1:0] res_data_q;
  logic              out_valid_q;
  out_item_t         out_item_q;
  logic              accept, out_free;
  pal_wr_t           pal_wr;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign pal_wr.en   = accept && (in_item_i.op == OpWrite) && (in_item_i.entry_index < LastIdx);
  assign pal_wr.addr = in_item_i.entry_index;
  assign pal_wr.data = {in_item_i.blue, in_item_i.green, in_item_i.red};

  rgbnpi_palette #(
    .Entries(PALETTE_ENTRIES),
    .AddrW  (AW)
  ) u_palette (
    .clk_i,
    .rst_ni,
    .wr_i     (pal_wr),
    .rd_addr_i(scan_addr_q),
    .rd_data_o(rd_data)
  );

  assign dist_sum = DistW'(sq_r_q) + DistW'(sq_g_q) + DistW'(sq_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      scan_addr_q <= '0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s1_idx_q    <= '0;
      s2_idx_q    <= '0;
      s2_data_q   <= '0;
      sq_r_q      <= '0;
      sq_g_q      <= '0;
      sq_b_q      <= '0;
      q_r_q       <= '0;
      q_g_q       <= '0;
      q_b_q       <= '0;
      best_d_q    <= '0;
      res_index_q <= '0;
      res_data_q  <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      if (out_ready_i && (state_q != StFinish)) begin
        out_valid_q <= 1'b0;
      end

      // read, square and compare stages
      s1_vld_q  <= (state_q == StScan);
      s1_idx_q  <= scan_addr_q;
      s2_vld_q  <= s1_vld_q;
      s2_idx_q  <= s1_idx_q;
      s2_data_q <= rd_data;
      sq_r_q    <= chan_sq(q_r_q, rd_data[ChanW-1:0]);
      sq_g_q    <= chan_sq(q_g_q, rd_data[2*ChanW-1:ChanW]);
      sq_b_q    <= chan_sq(q_b_q, rd_data[3*ChanW-1:2*ChanW]);

      if (s2_vld_q && ((s2_idx_q == '0) || (dist_sum < best_d_q))) begin
        best_d_q    <= dist_sum;
        res_index_q <= ChanW'(s2_idx_q);
        res_data_q  <= s2_data_q;
      end

      unique case (state_q)
        StIdle: begin
          if (accept) begin
            if (in_item_i.op == OpWrite) begin
              res_index_q <= in_item_i.entry_index;
              res_data_q  <= {in_item_i.blue, in_item_i.green, in_item_i.red};
              state_q     <= StFinish;
            end else begin
              q_r_q       <= expand5(in_item_i.color15[4:0]);
              q_g_q       <= expand5(in_item_i.color15[9:5]);
              q_b_q       <= expand5(in_item_i.color15[14:10]);
              scan_addr_q <= '0;
              state_q     <= StScan;
            end
          end
        end
        StScan: begin
          if (scan_addr_q == LastAddr) begin
            state_q <= StDrain;
          end else begin
            scan_addr_q <= scan_addr_q + 1'b1;
          end
        end
        StDrain: begin
          if (s2_vld_q && (s2_idx_q == LastAddr)) begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          if (out_free) begin
            out_valid_q             <= 1'b1;
            out_item_q.best_index   <= res_index_q;
            // the transparent entry and anything above it pack to zero
            out_item_q.packed_entry <= (res_index_q >= LastIdx) ? '0
                                       : {AlphaFull, res_data_q};
            state_q                 <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != StIdle))
    else $error("accepted item did not start work");

  a_pipe_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> ((state_q == StScan) || (state_q == StDrain)))
    else $error("compare stage active outside a scan");

  a_finish_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinish) |-> (!s1_vld_q && !s2_vld_q))
    else $error("result issued before the scan pipe drained");

  a_transparent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_item_q.best_index >= LastIdx)) |-> (out_item_q.packed_entry == '0))
    else $error("transparent entry packed to a non-zero word");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rgbnpi_pkg::*;

  localparam int PAL_N = 256;
  // longest legal quiet stretch is the receiver hold-off plus one full scan
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  rgb555_nearest_palette_index #(
    .PALETTE_ENTRIES(PAL_N)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  logic [23:0] shadow_palette [PAL_N];
  out_item_t   pending_results [$];
  int          mismatches;
  bit          idle_en;
  int          hold_req;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  function automatic logic [WordW-1:0] entry_word(input logic [ChanW-1:0] idx);
    if (idx >= 8'(PAL_N - 1)) return '0;
    return {AlphaFull, shadow_palette[idx]};
  endfunction

  // expected result of one item; a write below the transparent entry also updates the shadow palette
  function automatic out_item_t predict_nearest_entry(input in_item_t it);
    out_item_t   res;
    int          qr, qg, qb, dr, dg, db;
    int unsigned d, best_d;
    logic [7:0]  best;
    logic [23:0] e;
    if (it.op == OpWrite) begin
      if (it.entry_index < 8'(PAL_N - 1))
        shadow_palette[it.entry_index] = {it.blue, it.green, it.red};
      res.best_index   = it.entry_index;
      res.packed_entry = entry_word(it.entry_index);
    end else begin
      qr = int'(it.color15[4:0]) * 8 + 4;
      qg = int'(it.color15[9:5]) * 8 + 4;
      qb = int'(it.color15[14:10]) * 8 + 4;
      best   = '0;
      best_d = 0;
      for (int v = 0; v < PAL_N; v++) begin
        // the transparent entry always scans as black
        e  = (v < PAL_N - 1) ? shadow_palette[v] : '0;
        dr = qr - int'(e[7:0]);
        dg = qg - int'(e[15:8]);
        db = qb - int'(e[23:16]);
        d  = dr * dr + dg * dg + db * db;
        if (v == 0 || d < best_d) begin
          best   = 8'(v);
          best_d = d;
        end
      end
      res.best_index   = best;
      res.packed_entry = entry_word(best);
    end
    return res;
  endfunction

  function automatic in_item_t write_item(input logic [7:0] idx, input logic [7:0] r,
                                          input logic [7:0] g, input logic [7:0] b);
    in_item_t it;
    it.op          = OpWrite;
    it.entry_index = idx;
    it.red         = r;
    it.green       = g;
    it.blue        = b;
    it.color15     = 15'($urandom);
    return it;
  endfunction

  function automatic in_item_t query_item(input logic [14:0] c);
    in_item_t it;
    it.op          = OpQuery;
    it.entry_index = 8'($urandom);
    it.red         = 8'($urandom);
    it.green       = 8'($urandom);
    it.blue        = 8'($urandom);
    it.color15     = c;
    return it;
  endfunction

  function automatic logic [14:0] color_of_entry(input logic [23:0] e);
    return {e[23:19], e[15:11], e[7:3]};
  endfunction

  // drive at the falling edge, accept at the rising edge
  task automatic send_item(input in_item_t it);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    pending_results.push_back(predict_nearest_entry(it));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_palette();
    send_item(query_item(15'h0000));
    send_item(query_item(15'h7FFF));
    send_item(query_item(15'h2AAA));
    send_item(query_item(15'h5555));
  endtask

  task automatic test_directed_entries();
    send_item(write_item(8'd0, 8'h00, 8'h00, 8'h00));
    send_item(write_item(8'd254, 8'hFF, 8'hFF, 8'hFF));
    send_item(write_item(8'd255, 8'($urandom), 8'($urandom), 8'($urandom)));
    send_item(write_item(8'd128, 8'hFF, 8'h00, 8'h00));
    send_item(query_item(15'h7FFF));
    send_item(query_item(15'h001F));
    // two identical entries, the lower index must win
    send_item(write_item(8'd10, 8'h44, 8'h84, 8'hC4));
    send_item(write_item(8'd20, 8'h44, 8'h84, 8'hC4));
    send_item(query_item(color_of_entry({8'hC4, 8'h84, 8'h44})));
    send_item(write_item(8'd1, 8'h04, 8'h04, 8'h04));
    send_item(query_item(15'h0000));
    send_item(write_item(8'd254, 8'h00, 8'hFF, 8'h00));
    send_item(query_item(15'h7FFF));
    // writing the transparent entry must leave it black
    send_item(write_item(8'd255, 8'hFF, 8'hFF, 8'hFF));
    send_item(query_item(15'h7FFF));
    send_item(query_item(15'h03E0));
  endtask

  // all normal entries bright, so dark queries land on the transparent entry
  task automatic test_transparent_nearest();
    for (int i = 0; i < PAL_N - 1; i++)
      send_item(write_item(8'(i), 8'($urandom_range(128, 255)),
                           8'($urandom_range(128, 255)), 8'($urandom_range(128, 255))));
    send_item(query_item(15'h0000));
    send_item(query_item(15'h0421));
    send_item(query_item(15'(($urandom & 15'h3DEF) & 15'h1CE7)));
    send_item(query_item(15'h7FFF));
  endtask

  task automatic test_random_traffic(input int n);
    int          sel;
    logic [7:0]  k;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      k   = 8'($urandom_range(0, PAL_N - 2));
      if (sel < 33) begin
        send_item(write_item(k, 8'($urandom), 8'($urandom), 8'($urandom)));
      end else if (sel < 36) begin
        send_item(write_item(8'd255, 8'($urandom), 8'($urandom), 8'($urandom)));
      end else if (sel < 43) begin
        // bucket-centred colour, an exact hit for some query
        send_item(write_item(k, {5'($urandom), 3'b100}, {5'($urandom), 3'b100},
                             {5'($urandom), 3'b100}));
      end else if (sel < 70) begin
        send_item(query_item(color_of_entry(shadow_palette[k]) ^
                             (15'($urandom) & 15'h0C63)));
      end else begin
        send_item(query_item(15'($urandom)));
      end
      if (i % 300 == 299) wait_drained();
    end
  endtask

  task automatic test_output_stall();
    hold_req = HOLD_CYCLES;
    repeat (6)
      send_item(write_item(8'($urandom_range(0, PAL_N - 2)), 8'($urandom), 8'($urandom),
                           8'($urandom)));
    send_item(query_item(15'($urandom)));
    send_item(query_item(15'($urandom)));
  endtask

  task automatic test_full_rate(input int n);
    wait_drained();
    idle_en = 1'b0;
    test_random_traffic(n);
  endtask

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin : receiver
    int n;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        n        = hold_req;
        hold_req = 0;
        out_ready_i <= 1'b0;
        for (int c = 1; c < n; c++) @(negedge clk_i);
      end else if (idle_en && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result index %0d word %08h",
                                  out_item_o.best_index, out_item_o.packed_entry));
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.best_index !== want.best_index)
          report_mismatch($sformatf("best_index %0d, expected %0d",
                                    out_item_o.best_index, want.best_index));
        if (out_item_o.packed_entry !== want.packed_entry)
          report_mismatch($sformatf("packed_entry %08h, expected %08h",
                                    out_item_o.packed_entry, want.packed_entry));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    mismatches = 0;
    idle_en    = 1'b1;
    hold_req   = 0;
    for (int i = 0; i < PAL_N; i++) shadow_palette[i] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_palette();
    test_directed_entries();
    test_transparent_nearest();
    test_random_traffic(450);
    test_output_stall();
    wait_drained();
    test_random_traffic(450);
    test_full_rate(260);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/rgbnpi_pkg.sv
hdl/rgbnpi_palette.sv
hdl/rgb555_nearest_palette_index.sv
tb/testbench.sv
